/* rtl/bdm_pkg.sv */
// Types, constants and the popcount helper shared by the best-match block.
`default_nettype none
package bdm_pkg;

  localparam int NUM_LEVELS    = 8;
  localparam int MAX_KEYPOINTS = 4096;
  localparam int DESC_W        = 256;
  localparam int WORD_W        = 64;
  localparam int LEVEL_W       = 3;
  localparam int INDEX_W       = 12;
  localparam int DIST_W        = 9;
  localparam int CHUNK_W       = 32;
  localparam int NUM_CHUNKS    = DESC_W / CHUNK_W;
  localparam int CHUNK_CNT_W   = 6;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 9'd50;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_QUERY     = 1'b0;
  localparam logic MODE_CANDIDATE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [WORD_W-1:0]  desc_word0;
    logic [WORD_W-1:0]  desc_word1;
    logic [WORD_W-1:0]  desc_word2;
    logic [WORD_W-1:0]  desc_word3;
    logic [LEVEL_W-1:0] scale_level;
    logic [INDEX_W-1:0] candidate_index;
    logic               already_taken;
    logic               last_candidate;
  } in_item_t;

  typedef struct packed {
    logic               any_eligible;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
    logic               matched;
  } out_item_t;

  // One classified beat handed from the front end to the back end.
  typedef struct packed {
    logic               is_candidate;
    logic               eligible;
    logic               last;
    logic [INDEX_W-1:0] index;
    logic [DESC_W-1:0]  diff;
  } work_t;

  function automatic logic [CHUNK_CNT_W-1:0] popcnt32(input logic [CHUNK_W-1:0] x);
    logic [CHUNK_W-1:0] v;
    v = x - ((x >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0F0F_0F0F;
    return CHUNK_CNT_W'(v[7:0]) + CHUNK_CNT_W'(v[15:8])
         + CHUNK_CNT_W'(v[23:16]) + CHUNK_CNT_W'(v[31:24]);
  endfunction

endpackage
`default_nettype wire

/* rtl/bdm_front.sv */
// Front end: holds the query, classifies candidates and forms the XOR difference.
`default_nettype none
module bdm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire bdm_pkg::in_item_t item,
  output bdm_pkg::work_t        work
);
  import bdm_pkg::*;

  logic [DESC_W-1:0]  query_desc;
  logic [LEVEL_W-1:0] query_level;
  logic [DESC_W-1:0]  item_desc;
  logic [LEVEL_W:0]   lvl;
  logic [LEVEL_W:0]   qlvl;
  logic               eligible;

  assign item_desc = {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0};

  always_ff @(posedge clk) begin
    if (rst) begin
      query_desc  <= '0;
      query_level <= '0;
    end else if (accept && item.mode == MODE_QUERY) begin
      query_desc  <= item_desc;
      query_level <= item.scale_level;
    end
  end

  // Level must lie in [predicted-1, predicted]; compare one bit wider to avoid wrap.
  always_comb begin
    lvl  = {1'b0, item.scale_level};
    qlvl = {1'b0, query_level};
    eligible = !item.already_taken
            && (lvl < (LEVEL_W+1)'(NUM_LEVELS))
            && ({1'b0, item.candidate_index} < (INDEX_W+1)'(MAX_KEYPOINTS))
            && (lvl <= qlvl)
            && ((lvl + 1'b1) >= qlvl);
  end

  always_comb begin
    work.is_candidate = (item.mode == MODE_CANDIDATE);
    work.eligible     = eligible;
    work.last         = (item.mode == MODE_CANDIDATE) && item.last_candidate;
    work.index        = item.candidate_index;
    work.diff         = query_desc ^ item_desc;
  end

endmodule
`default_nettype wire

/* rtl/bdm_queue.sv */
// Short queue between the front and back ends.
`default_nettype none
module bdm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bdm_pkg::work_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output bdm_pkg::work_t      head
);
  import bdm_pkg::*;

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/bdm_back.sv */
// Back end: chunk popcounts, running minimum and the result register.
`default_nettype none
module bdm_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      head_valid,
  input  wire bdm_pkg::work_t            head,
  output logic                           pop,
  input  wire logic [bdm_pkg::DIST_W-1:0] threshold,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bdm_pkg::out_item_t             out_item
);
  import bdm_pkg::*;

  logic                   adv;

  // popcount stage
  logic                   a_valid;
  logic                   a_cand;
  logic                   a_elig;
  logic                   a_last;
  logic [INDEX_W-1:0]     a_index;
  logic [CHUNK_CNT_W-1:0] a_cnt [NUM_CHUNKS];

  // running search
  logic                   have_best;
  logic [DIST_W-1:0]      best_dist;
  logic [INDEX_W-1:0]     best_idx;
  logic                   have_best_next;
  logic [DIST_W-1:0]      best_dist_next;
  logic [INDEX_W-1:0]     best_idx_next;
  logic [DIST_W-1:0]      cand_dist;
  logic                   emit;
  logic                   upd_have;
  logic [DIST_W-1:0]      upd_dist;
  logic [INDEX_W-1:0]     upd_idx;

  // Advance the whole back end unless a result is held by the consumer.
  assign adv = !out_valid || !out_stall;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cand  <= head.is_candidate;
      a_elig  <= head.eligible;
      a_last  <= head.last;
      a_index <= head.index;
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        a_cnt[c] <= popcnt32(head.diff[c*CHUNK_W +: CHUNK_W]);
      end
    end
  end

  always_comb begin
    cand_dist = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      cand_dist = cand_dist + DIST_W'(a_cnt[c]);
    end
  end

  always_comb begin
    upd_have = have_best;
    upd_dist = best_dist;
    upd_idx  = best_idx;
    if (a_cand && a_elig && (!have_best || cand_dist < best_dist)) begin
      upd_have = 1'b1;
      upd_dist = cand_dist;
      upd_idx  = a_index;
    end
    emit           = a_valid && adv && a_cand && a_last;
    have_best_next = have_best;
    best_dist_next = best_dist;
    best_idx_next  = best_idx;
    if (a_valid && adv) begin
      if (!a_cand || a_last) begin
        // a query or a finished search starts afresh
        have_best_next = 1'b0;
        best_dist_next = '0;
        best_idx_next  = '0;
      end else begin
        have_best_next = upd_have;
        best_dist_next = upd_dist;
        best_idx_next  = upd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_dist <= '0;
      best_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      have_best <= have_best_next;
      best_dist <= best_dist_next;
      best_idx  <= best_idx_next;
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.any_eligible  <= upd_have;
      out_item.best_index    <= upd_have ? upd_idx : '0;
      out_item.best_distance <= upd_have ? upd_dist : '0;
      out_item.matched       <= upd_have && (upd_dist <= threshold);
    end
  end

endmodule
`default_nettype wire

/* rtl/binary_descriptor_best_match.sv */
// Top level of the 256-bit binary descriptor best-match block.
`default_nettype none
// Hamming nearest-neighbour search over 256-bit descriptors. A query beat
// (mode 0) loads the descriptor and predicted level and restarts the search;
// candidate beats (mode 1) follow and one result beat leaves after the
// candidate flagged last. One beat is accepted per cycle while in_stall is
// low. A result passes from the queue entry through the chunk popcount stage,
// then the 256-bit sum and compare into the result register. A four-entry
// queue decouples input from the back end, so in_stall rises only once that
// queue is full. match_threshold is written through the cfg channel, which
// is always ready, and is read when a result is formed.
module binary_descriptor_best_match (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bdm_pkg::in_item_t          in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bdm_pkg::out_item_t              out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bdm_pkg::DIST_W-1:0] cfg_data
);
  import bdm_pkg::*;

  logic              accept;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  work_t             front_work;
  work_t             q_head;
  logic [DIST_W-1:0] match_threshold;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      match_threshold <= cfg_data;
    end
  end

  bdm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .work   (front_work)
  );

  bdm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_work),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bdm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (q_pop),
    .threshold  (match_threshold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
